// File: rtl/bdar_pkg.sv
// Shared types and codes for the button debouncer with auto-repeat.
// No dependencies; imported by every module of the block.
package bdar_pkg;

  // Event selector carried with each input word
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_LEFT  = 2'd1,
    FUNC_RIGHT = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  // Button codes
  localparam logic [1:0] BTN_NONE  = 2'd0;
  localparam logic [1:0] BTN_LEFT  = 2'd1;
  localparam logic [1:0] BTN_RIGHT = 2'd2;

  // Phase codes (state of the debounce sequencer)
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PRESS   = 2'd1;
  localparam logic [1:0] PH_HELD    = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_POLL     = 2'd1;
  localparam logic [1:0] REG_HOLD     = 2'd2;

  // Register reset values
  localparam logic [15:0] DEBOUNCE_RST = 16'd1000;
  localparam logic [15:0] POLL_RST     = 16'd100;
  localparam logic [7:0]  HOLD_RST     = 8'd10;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] poll_ticks;
    logic [7:0]  hold_polls;
  } cfg_t;

  typedef struct packed {
    func_e func;
    logic  left_level;
    logic  right_level;
  } item_t;

  typedef struct packed {
    logic [1:0] pressed_code;
    logic [1:0] phase;
  } result_t;

  // Sequencer status for checking
  typedef struct packed {
    logic [1:0] phase;
    logic [1:0] active_button;
    logic [1:0] latched_button;
  } status_t;

endpackage

// File: rtl/bdar_regs.sv
// Configuration register file: debounce, poll and hold-count settings.
// Depends on bdar_pkg.
module bdar_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output bdar_pkg::cfg_t     cfg_o
);
  import bdar_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  // Decode write; unknown index is dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEBOUNCE: cfg_d.debounce_ticks = cfg_data_i;
        REG_POLL:     cfg_d.poll_ticks     = cfg_data_i;
        REG_HOLD:     cfg_d.hold_polls     = cfg_data_i[7:0];
        default:      cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= DEBOUNCE_RST;
      cfg_q.poll_ticks     <= POLL_RST;
      cfg_q.hold_polls     <= HOLD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/bdar_fsm.sv
// Debounce sequencer: phase, button and counter state, updated once per word.
// Depends on bdar_pkg.
module bdar_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  bdar_pkg::item_t    item_i,
  input  bdar_pkg::cfg_t     cfg_i,
  output bdar_pkg::result_t  res_o,
  output bdar_pkg::status_t  status_o
);
  import bdar_pkg::*;

  logic [1:0]  phase_q, phase_d;
  logic [1:0]  active_q, active_d;
  logic [1:0]  latched_q, latched_d;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] tick_q, tick_d;

  logic [15:0] period;
  logic [15:0] tick_inc;
  logic        released;
  logic [1:0]  code;

  assign period   = (phase_q == PH_HELD) ? cfg_i.poll_ticks : cfg_i.debounce_ticks;
  assign tick_inc = tick_q + 16'd1;
  assign released = (active_q == BTN_RIGHT && item_i.right_level) ||
                    (active_q == BTN_LEFT  && item_i.left_level);

  // Next state for one event
  always_comb begin
    phase_d   = phase_q;
    active_d  = active_q;
    latched_d = latched_q;
    hold_d    = hold_q;
    tick_d    = tick_q;
    code      = BTN_NONE;
    case (item_i.func)
      FUNC_TICK: begin
        if (phase_q != PH_IDLE) begin
          // a zero period acts as one: the compare always passes
          if (tick_inc < period) begin
            tick_d = tick_inc;
          end else begin
            tick_d = '0;
            case (phase_q)
              PH_PRESS: phase_d = PH_HELD;
              PH_HELD: begin
                if (released) begin
                  phase_d = PH_RELEASE;
                end else if (hold_q == cfg_i.hold_polls) begin
                  hold_d    = '0;
                  latched_d = active_q;
                end else begin
                  hold_d = hold_q + 8'd1;
                end
              end
              default: begin
                phase_d  = PH_IDLE;
                active_d = BTN_NONE;
              end
            endcase
          end
        end
      end
      FUNC_READ: begin
        code      = latched_q;
        latched_d = BTN_NONE;
      end
      default: begin
        // edges count only while idle
        if (phase_q == PH_IDLE) begin
          latched_d = (item_i.func == FUNC_LEFT) ? BTN_LEFT : BTN_RIGHT;
          active_d  = latched_d;
          hold_d    = '0;
          tick_d    = '0;
          phase_d   = PH_PRESS;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      active_q  <= BTN_NONE;
      latched_q <= BTN_NONE;
      hold_q    <= '0;
      tick_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      active_q  <= active_d;
      latched_q <= latched_d;
      hold_q    <= hold_d;
      tick_q    <= tick_d;
    end
  end

  assign res_o.pressed_code = code;
  assign res_o.phase        = phase_d;

  assign status_o.phase          = phase_q;
  assign status_o.active_button  = active_q;
  assign status_o.latched_button = latched_q;

endmodule

// File: rtl/button_debounce_autorepeat.sv
// Top level of the two-button debouncer with hold auto-repeat.
// Depends on bdar_pkg, bdar_regs and bdar_fsm.
//
// Every word (tick, left edge, right edge or status read) yields one result
// word carrying the read code and the phase after the event. The block takes
// one word per clock while the result side keeps up: a word is held in the
// input register, and the sequencer updates its state as the word moves to
// the output register. The output register frees itself on the same edge
// it is taken, so a stall on the result side stalls the input only while
// both registers are full. Configuration writes are always accepted and
// are registered in bdar_regs; write only while no word is in flight.
module button_debounce_autorepeat (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] left_level, [1] right_level, [7:2] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] func
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [1:0] pressed_code, [3:2] phase, [7:4] zero
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import bdar_pkg::*;

  cfg_t    cfg;
  result_t res;
  status_t status;

  logic    in_valid_q;
  item_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  logic    advance;

  bdar_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // word moves from input to output register
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  bdar_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .res_o    (res),
    .status_o (status)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q.func        <= func_e'(s_axis_tuser_i);
      in_q.left_level  <= s_axis_tdata_i[0];
      in_q.right_level <= s_axis_tdata_i[1];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_q.phase, out_q.pressed_code};

  // Checks
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[1:0] != 2'd3))
    else $error("result carries an undefined button code");

  a_idle_no_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.phase == PH_IDLE) == (status.active_button == BTN_NONE))
    else $error("active button out of step with phase");

  a_latched_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.latched_button != 2'd3)
    else $error("latched button holds an undefined code");

endmodule
